FILE: sv/lzsa2_pkg.sv
// LZSA2 block decoder: shared types and constants.
// No dependencies.
package lzsa2_pkg;

  typedef enum logic [3:0] {
    PH_TOKEN     = 4'd0,
    PH_LITNIB    = 4'd1,
    PH_LITEXT    = 4'd2,
    PH_LIT16LO   = 4'd3,
    PH_LIT16HI   = 4'd4,
    PH_LITERAL   = 4'd5,
    PH_OFFNIB    = 4'd6,
    PH_OFF9      = 4'd7,
    PH_OFF13LO   = 4'd8,
    PH_OFF16HI   = 4'd9,
    PH_OFF16LO   = 4'd10,
    PH_MATCHNIB  = 4'd11,
    PH_MATCHEXT  = 4'd12,
    PH_MATCH16LO = 4'd13,
    PH_MATCH16HI = 4'd14,
    PH_COPY      = 4'd15
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LIT    = 2'd0,
    KIND_COPY   = 2'd1,
    KIND_END    = 2'd2,
    KIND_REFUSE = 2'd3
  } kind_e;

  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [7:0] LIT_EXT16    = 8'd239;
  localparam logic [7:0] MATCH_EXT_MAX = 8'd231;
  localparam logic [7:0] MATCH_EXT16  = 8'd233;

  // History write / read request from the parser to the ring.
  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [15:0] rd_addr;
  } hist_req_t;

endpackage

FILE: sv/lzsa2_history.sv
// LZSA2 history ring: single-port-write, single-read synchronous memory.
// Depends on lzsa2_pkg. Read data is registered and appears in the cycle after rd_en.
module lzsa2_history import lzsa2_pkg::*; #(
  parameter int unsigned AW = 16
) (
  input  logic            clk_i,
  input  hist_req_t       req_i,
  output logic [7:0]      rd_data_o
);
  logic [7:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) mem_q[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) rd_data_o <= mem_q[req_i.rd_addr[AW-1:0]];
  end
endmodule

FILE: sv/lzsa2_block_decoder.sv
// LZSA2 block decoder top level: token parser, copy engine, result queue.
// Depends on lzsa2_pkg and lzsa2_history.
//
//  channel | valid   | ready   | payload
//  in      | valid_i | ready_o | opcode_i, in_byte_i
//  out     | valid_o | ready_i | out_byte_o, kind_o, last_of_copy_o
//
// One item per cycle on both sides while ready_o and ready_i allow, drain ticks included.
// Literal, end and refused items are written to the result queue when their
// input item is accepted; a copied byte goes to the ring read register, then
// to the queue. Copies of distance 1 are served by forwarding the byte written
// in the read cycle. Results wait in a two-entry queue; ready_o drops when the
// queue could not take the copy byte in flight plus what the item produces.
// Reset clears parser state and write position; history is not cleared.
module lzsa2_block_decoder import lzsa2_pkg::*; #(
  parameter int unsigned WINDOW_BYTES = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic       opcode_i,
  input  logic [7:0] in_byte_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_of_copy_o
);
  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  phase_e      phase_q, phase_d;
  logic [7:0]  token_q, token_d;
  logic        nib_pend_q, nib_pend_d;
  logic [3:0]  nib_q, nib_d;
  logic [15:0] lit_left_q, lit_left_d;
  logic [15:0] copy_left_q, copy_left_d;
  logic [15:0] last_off_q, last_off_d;
  logic [AW-1:0] copy_src_q, copy_src_d;
  logic [AW-1:0] wpos_q, wpos_d;
  logic [15:0] gather_q, gather_d;

  // pending copy byte (read issued last cycle)
  logic        cp_pend_q;
  logic        cp_last_q;
  logic        cp_fwd_q;     // read hit the address written in the same cycle
  logic [7:0]  fwd_data_q;   // data written in the read cycle
  logic [AW-1:0] cp_waddr_q;

  // result queue, head at entry 0
  logic [1:0]  ocnt_q, ocnt_d;
  logic [7:0]  ob_q [2];
  logic [7:0]  ob_d [2];
  logic [1:0]  ok_q [2];
  logic [1:0]  ok_d [2];
  logic        ol_q [2];
  logic        ol_d [2];
  logic        pop;

  logic [7:0]  rd_data;
  hist_req_t   req;
  logic        accept;
  logic [7:0]  cp_byte;

  // emit logic from current item
  logic        emit;
  logic [7:0]  e_byte;
  kind_e       e_kind;
  logic        e_last;

  // Take an item only if the queue can hold the copy byte in flight plus
  // whatever this item produces, counting the entry leaving this cycle.
  assign pop     = (ocnt_q != 2'd0) && ready_i;
  assign ready_o = (ocnt_q == 2'd0) ||
                   (ocnt_q == 2'd1 && (!cp_pend_q || ready_i)) ||
                   (ocnt_q == 2'd2 && !cp_pend_q && ready_i);
  assign accept  = valid_i && ready_o;
  assign cp_byte = cp_fwd_q ? fwd_data_q : rd_data;

  function automatic logic [AW-1:0] start_src(input logic [AW-1:0] wp, input logic [15:0] off);
    logic [15:0] span;
    span = 16'h0000 - off;
    return wp - span[AW-1:0];
  endfunction

  // parser helpers as combinational sequence on shadow variables
  always_comb begin
    logic [3:0] n;
    logic       have_n;
    logic [15:0] mlen;
    logic        do_match, do_copy, do_off;
    phase_d     = phase_q;
    token_d     = token_q;
    nib_pend_d  = nib_pend_q;
    nib_d       = nib_q;
    lit_left_d  = lit_left_q;
    copy_left_d = copy_left_q;
    last_off_d  = last_off_q;
    copy_src_d  = copy_src_q;
    wpos_d      = wpos_q;
    gather_d    = gather_q;
    emit = 1'b0; e_byte = 8'd0; e_kind = KIND_LIT; e_last = 1'b0;
    req = '0;
    n = 4'd0; have_n = 1'b0; mlen = 16'd0;
    do_match = 1'b0; do_copy = 1'b0; do_off = 1'b0;

    if (accept && opcode_i == OP_DRAIN) begin
      if (phase_q == PH_COPY && copy_left_q != 16'd0) begin
        req.rd_en   = 1'b1;
        req.rd_addr = 16'(copy_src_q);
        copy_src_d  = copy_src_q + 1'b1;
        copy_left_d = copy_left_q - 1'b1;
        wpos_d      = wpos_q + 1'b1;
        if (copy_left_q == 16'd1) phase_d = PH_TOKEN;
      end
    end else if (accept) begin
      unique case (phase_q)
        PH_TOKEN: begin
          token_d = in_byte_i;
          if (in_byte_i[4:3] == 2'd3) begin
            if (nib_pend_q) begin
              nib_pend_d = 1'b0;
              if (nib_q == 4'hF) phase_d = PH_LITEXT;
              else begin
                lit_left_d = 16'd3 + 16'(nib_q);
                phase_d = PH_LITERAL;
              end
            end else phase_d = PH_LITNIB;
          end else begin
            lit_left_d = 16'(in_byte_i[4:3]);
            if (in_byte_i[4:3] != 2'd0) phase_d = PH_LITERAL;
            else do_off = 1'b1;
          end
        end
        PH_LITNIB: begin
          nib_d = in_byte_i[3:0]; nib_pend_d = 1'b1;
          if (in_byte_i[7:4] == 4'hF) phase_d = PH_LITEXT;
          else begin
            lit_left_d = 16'd3 + 16'(in_byte_i[7:4]);
            phase_d = PH_LITERAL;
          end
        end
        PH_LITEXT: begin
          if (in_byte_i == LIT_EXT16) phase_d = PH_LIT16LO;
          else begin
            lit_left_d = 16'd18 + 16'(in_byte_i);
            phase_d = PH_LITERAL;
          end
        end
        PH_LIT16LO: begin
          gather_d = 16'(in_byte_i);
          phase_d = PH_LIT16HI;
        end
        PH_LIT16HI: begin
          lit_left_d = {in_byte_i, gather_q[7:0]};
          if ({in_byte_i, gather_q[7:0]} != 16'd0) phase_d = PH_LITERAL;
          else do_off = 1'b1;
        end
        PH_LITERAL: begin
          req.wr_en = 1'b1; req.wr_addr = 16'(wpos_q); req.wr_data = in_byte_i;
          wpos_d = wpos_q + 1'b1;
          emit = 1'b1; e_byte = in_byte_i; e_kind = KIND_LIT;
          if (lit_left_q != 16'd0) lit_left_d = lit_left_q - 1'b1;
          if (lit_left_q <= 16'd1) do_off = 1'b1;
        end
        PH_OFFNIB: begin
          nib_d = in_byte_i[3:0]; nib_pend_d = 1'b1;
          n = in_byte_i[7:4]; have_n = 1'b1;
        end
        PH_OFF9: begin
          last_off_d = {7'h7F, ~token_q[5], in_byte_i};
          do_match = 1'b1;
        end
        PH_OFF13LO: begin
          last_off_d = (gather_q | 16'(in_byte_i)) - 16'd512;
          do_match = 1'b1;
        end
        PH_OFF16HI: begin
          gather_d = {in_byte_i, 8'd0};
          phase_d = PH_OFF16LO;
        end
        PH_OFF16LO: begin
          last_off_d = gather_q | 16'(in_byte_i);
          do_match = 1'b1;
        end
        PH_MATCHNIB: begin
          nib_d = in_byte_i[3:0]; nib_pend_d = 1'b1;
          if (in_byte_i[7:4] == 4'hF) phase_d = PH_MATCHEXT;
          else begin mlen = 16'd9 + 16'(in_byte_i[7:4]); do_copy = 1'b1; end
        end
        PH_MATCHEXT: begin
          if (in_byte_i <= MATCH_EXT_MAX) begin
            mlen = 16'd24 + 16'(in_byte_i); do_copy = 1'b1;
          end else if (in_byte_i == MATCH_EXT16) phase_d = PH_MATCH16LO;
          else begin
            phase_d = PH_TOKEN; token_d = '0; nib_pend_d = 1'b0; nib_d = '0;
            lit_left_d = '0; copy_left_d = '0; last_off_d = '0;
            copy_src_d = '0; gather_d = '0;
            emit = 1'b1; e_kind = KIND_END;
          end
        end
        PH_MATCH16LO: begin
          gather_d = 16'(in_byte_i);
          phase_d = PH_MATCH16HI;
        end
        PH_MATCH16HI: begin
          mlen = {in_byte_i, gather_q[7:0]}; do_copy = 1'b1;
        end
        PH_COPY: begin
          emit = 1'b1; e_kind = KIND_REFUSE;
        end
        default: ;
      endcase

      // offset stage (after literals); token_d holds the new token in the
      // token phase
      if (do_off) begin
        if (token_d[7:6] == 2'b01) phase_d = PH_OFF9;
        else if (token_d[7:6] == 2'b11) begin
          if (token_d[5]) do_match = 1'b1;
          else phase_d = PH_OFF16HI;
        end else if (nib_pend_d) begin
          n = nib_d; have_n = 1'b1; nib_pend_d = 1'b0;
        end else phase_d = PH_OFFNIB;
      end
      if (have_n) begin
        if (token_d[7:6] == 2'b00) begin
          last_off_d = {11'h7FF, n, ~token_d[5]};
          do_match = 1'b1;
        end else begin
          gather_d = {3'b111, n, ~token_d[5], 8'd0};
          phase_d = PH_OFF13LO;
        end
      end
      if (do_match) begin
        if (token_d[2:0] != 3'd7) begin
          mlen = 16'(token_d[2:0]) + 16'd2; do_copy = 1'b1;
        end else if (nib_pend_d) begin
          nib_pend_d = 1'b0;
          if (nib_d == 4'hF) phase_d = PH_MATCHEXT;
          else begin mlen = 16'd9 + 16'(nib_d); do_copy = 1'b1; end
        end else phase_d = PH_MATCHNIB;
      end
      if (do_copy) begin
        copy_src_d  = start_src(wpos_d, last_off_d);
        copy_left_d = mlen;
        phase_d     = (mlen != 16'd0) ? PH_COPY : PH_TOKEN;
      end
    end

    // copy byte from last cycle: write it back at its slot
    if (cp_pend_q) begin
      req.wr_en   = 1'b1;
      req.wr_addr = 16'(cp_waddr_q);
      req.wr_data = cp_byte;
    end
  end

  // queue update: pop the head, then append the copy byte (older) and the
  // result of the item taken this cycle
  always_comb begin
    logic [1:0] fill;
    fill = ocnt_q;
    ob_d = ob_q;
    ok_d = ok_q;
    ol_d = ol_q;
    if (pop) begin
      ob_d[0] = ob_q[1]; ok_d[0] = ok_q[1]; ol_d[0] = ol_q[1];
      fill = fill - 2'd1;
    end
    if (cp_pend_q) begin
      ob_d[fill[0]] = cp_byte; ok_d[fill[0]] = KIND_COPY; ol_d[fill[0]] = cp_last_q;
      fill = fill + 2'd1;
    end
    if (emit) begin
      ob_d[fill[0]] = e_byte; ok_d[fill[0]] = e_kind; ol_d[fill[0]] = e_last;
      fill = fill + 2'd1;
    end
    ocnt_d = fill;
  end

  lzsa2_history #(.AW(AW)) u_hist (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN; token_q <= '0; nib_pend_q <= 1'b0; nib_q <= '0;
      lit_left_q <= '0; copy_left_q <= '0; last_off_q <= '0;
      copy_src_q <= '0; wpos_q <= '0; gather_q <= '0;
      cp_pend_q <= 1'b0; cp_last_q <= 1'b0; cp_fwd_q <= 1'b0;
      ocnt_q <= '0;
      ob_q <= '{8'd0, 8'd0}; ok_q <= '{2'd0, 2'd0}; ol_q <= '{1'b0, 1'b0};
    end else begin
      phase_q <= phase_d; token_q <= token_d; nib_pend_q <= nib_pend_d; nib_q <= nib_d;
      lit_left_q <= lit_left_d; copy_left_q <= copy_left_d; last_off_q <= last_off_d;
      copy_src_q <= copy_src_d; wpos_q <= wpos_d; gather_q <= gather_d;
      cp_pend_q <= req.rd_en;
      cp_last_q <= req.rd_en && copy_left_q == 16'd1;
      cp_fwd_q  <= req.rd_en && req.wr_en && req.wr_addr == req.rd_addr;
      ocnt_q <= ocnt_d;
      ob_q   <= ob_d;
      ok_q   <= ok_d;
      ol_q   <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= req.wr_data;
    if (req.rd_en) cp_waddr_q <= wpos_q;
  end

  assign valid_o        = (ocnt_q != 2'd0);
  assign out_byte_o     = ob_q[0];
  assign kind_o         = ok_q[0];
  assign last_of_copy_o = ol_q[0];
endmodule
